// File: design/segment_strain_limiter_macros.svh
// Assertion macros for the segment strain limiter checker.
`ifndef SEGMENT_STRAIN_LIMITER_MACROS_SVH
`define SEGMENT_STRAIN_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SSL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssl checker: same-cycle rule broken");

// Next-cycle implication, sampled on clock, off during reset.
`define SSL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssl checker: next-cycle rule broken");

`endif

// File: design/ssl_pkg.sv
// Shared types, codes, constants and saturation helpers of the strain limiter.
`default_nettype none
package ssl_pkg;
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 12;
   localparam int REST_W    = 63;
   localparam int COORD_W   = 32;
   localparam int CFG_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam int PARTICLES_DEFAULT = 4096;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LIMIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_UPPER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRETCH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COMPRESS = 2'd3;

   localparam logic [CFG_W-1:0] UPPER_RST    = 17'd79299;
   localparam logic [CFG_W-1:0] LOWER_RST    = 17'd53084;
   localparam logic [CFG_W-1:0] STRETCH_RST  = 17'd72090;
   localparam logic [CFG_W-1:0] COMPRESS_RST = 17'd58982;

   typedef logic signed [COORD_W-1:0] coord_type;

   function automatic coord_type sat33(input logic signed [32:0] v);
      coord_type r;
      if (v > 33'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   function automatic coord_type sat34(input logic signed [33:0] v);
      coord_type r;
      if (v > 34'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -34'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: design/segment_strain_limiter.sv
// Segment strain limiter: particle position store with length clamping.
`default_nettype none
// Usage
//  - Command channel: a beat is taken at a rising edge with start high and busy low.
//    req_cmd selects write, limit or read; code 3 does nothing and answers zeros.
//  - Result channel: one beat per command, shown for one cycle with rsp_strobe.
//    The receiver cannot stall; it must take the beat in that cycle.
//  - csr_we writes csr_wdata into register csr_index at once (ratios and targets).
//    Write only while idle.
//  - One command at a time: busy stays high until the result is launched.
//  - Limit: the squared length comes first; a zero length answers as degenerate. Otherwise
//    an upper compare multiply and, unless above it, a lower one follow; if corrected,
//    a restoring divider, a square root, one bit-serial multiply per component and a
//    write-back follow. The multiplier runs until its shifted operand is spent.
//  - The positions sit in one PARTICLES x 96 bit RAM, one write port, one registered read port.
//    Moved and anchor entries are read one after the other.
//    A write-back finishes before the next command can read.
//  - Reset (synchronous) sets the registers to their defaults and idles the block.
//    The RAM is not cleared: entries are undefined until written.
module segment_strain_limiter #(
   parameter int PARTICLES = ssl_pkg::PARTICLES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ssl_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [ssl_pkg::IDX_W-1:0]         req_moved_index,
   input  wire logic [ssl_pkg::IDX_W-1:0]         req_anchor_index,
   input  wire logic [ssl_pkg::REST_W-1:0]        req_rest_sq_length,
   input  wire logic signed [ssl_pkg::COORD_W-1:0] req_in_x,
   input  wire logic signed [ssl_pkg::COORD_W-1:0] req_in_y,
   input  wire logic signed [ssl_pkg::COORD_W-1:0] req_in_z,
   output logic                                   rsp_strobe,
   output logic signed [ssl_pkg::COORD_W-1:0]     rsp_out_x,
   output logic signed [ssl_pkg::COORD_W-1:0]     rsp_out_y,
   output logic signed [ssl_pkg::COORD_W-1:0]     rsp_out_z,
   output logic                                   rsp_corrected,
   output logic                                   rsp_degenerate,
   input  wire logic                              csr_we,
   input  wire logic [ssl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ssl_pkg::CFG_W-1:0]         csr_wdata
);
   import ssl_pkg::*;

   localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   // index modulo PARTICLES via reciprocal: exact for 12 bit indices
   localparam int RSH = 28;
   localparam logic [27:0] RECIP = 28'(((64'd1 << RSH) + PARTICLES - 1) / PARTICLES);
   localparam logic [16:0] PART17 = 17'(PARTICLES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_IDX1 = 4'd1;
   localparam logic [3:0] S_IDX2 = 4'd2;
   localparam logic [3:0] S_RDM  = 4'd3;
   localparam logic [3:0] S_RDA  = 4'd4;
   localparam logic [3:0] S_DIFF = 4'd5;
   localparam logic [3:0] S_SQ   = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_MULU = 4'd8;
   localparam logic [3:0] S_MULL = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_SQRT = 4'd11;
   localparam logic [3:0] S_MT   = 4'd12;
   localparam logic [3:0] S_MULS = 4'd13;
   localparam logic [3:0] S_WB   = 4'd14;

   // configuration
   logic [CFG_W-1:0] upper_ff, lower_ff, stretch_ff, compress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff    <= UPPER_RST;
         lower_ff    <= LOWER_RST;
         stretch_ff  <= STRETCH_RST;
         compress_ff <= COMPRESS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_UPPER:    upper_ff    <= csr_wdata;
            REG_LOWER:    lower_ff    <= csr_wdata;
            REG_STRETCH:  stretch_ff  <= csr_wdata;
            REG_COMPRESS: compress_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // position RAM, word = {z, y, x}
   logic [95:0]   mem [PARTICLES];
   logic [95:0]   rdata_ff;
   logic          we_in;
   logic [AW-1:0] waddr_in, raddr_in;
   logic [95:0]   wdata_in;

   always_ff @(posedge clock) begin
      if (we_in) mem[waddr_in] <= wdata_in;
      rdata_ff <= mem[raddr_in];
   end

   // command registers
   logic [3:0]         state_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [IDX_W-1:0]   mraw_ff, araw_ff, qm_ff, qa_ff;
   logic [AW-1:0]      m_ff, a_ff;
   logic [REST_W-1:0]  rest_ff;
   logic [95:0]        inpos_ff;
   coord_type          pm_ff [3];
   coord_type          pa_ff [3];
   coord_type          new_ff [3];
   logic [31:0]        mag_ff [3];
   logic               neg_ff [3];
   logic [63:0]        len_ff, prod_ff;
   logic [6:0]         cnt_ff;
   logic [1:0]         k_ff;
   logic [127:0]       acc_ff, mc_ff;
   logic [63:0]        mp_ff;
   logic [CFG_W-1:0]   tgt_ff;
   logic [126:0]       num_ff, sn_ff, bit_ff;
   logic [63:0]        rem_ff;
   logic [127:0]       res_ff;

   logic               rsp_strobe_ff, rsp_corr_ff, rsp_deg_ff;
   coord_type          rsp_x_ff, rsp_y_ff, rsp_z_ff;

   // index reduction
   logic [39:0] qm_prod_in, qa_prod_in;
   logic [16:0] mrem_in, arem_in;
   assign qm_prod_in = {28'd0, mraw_ff} * {12'd0, RECIP};
   assign qa_prod_in = {28'd0, araw_ff} * {12'd0, RECIP};
   assign mrem_in    = {5'd0, mraw_ff} - 17'(qm_ff * PART17);
   assign arem_in    = {5'd0, araw_ff} - 17'(qa_ff * PART17);

   // saturated differences (anchor word is in rdata_ff during S_DIFF)
   coord_type   dq_in [3];
   coord_type   d_in [3];
   logic [31:0] dmag_in [3];
   always_comb begin
      dq_in[0] = rdata_ff[31:0];
      dq_in[1] = rdata_ff[63:32];
      dq_in[2] = rdata_ff[95:64];
      for (int k = 0; k < 3; k++) begin
         d_in[k]    = sat33({pm_ff[k][31], pm_ff[k]} - {dq_in[k][31], dq_in[k]});
         dmag_in[k] = d_in[k][31] ? (~d_in[k] + 32'd1) : d_in[k];
      end
   end

   // shared magnitude select: a 32x32 square, then a 32x17 |d| * target product
   logic [1:0]  sel_in;
   logic [31:0] mag_sel_in;
   logic [63:0] sq_in, mt_in;
   always_comb begin
      sel_in = (state_ff == S_SQ) ? cnt_ff[1:0] : k_ff;
      case (sel_in)
         2'd0:    mag_sel_in = mag_ff[0];
         2'd1:    mag_sel_in = mag_ff[1];
         2'd2:    mag_sel_in = mag_ff[2];
         default: mag_sel_in = 32'd0;
      endcase
   end
   assign sq_in = mag_sel_in * mag_sel_in;
   assign mt_in = mag_sel_in * {15'd0, tgt_ff};

   // bit-serial multiplier step
   logic [127:0] acc_add_in;
   logic         mul_done_in;
   logic [79:0]  lsh_in;
   assign acc_add_in  = acc_ff + (mp_ff[0] ? mc_ff : 128'd0);
   assign mul_done_in = (mp_ff == 64'd0);
   assign lsh_in      = {len_ff, 16'd0};

   // restoring divider step
   logic [64:0]  rtrial_in;
   logic         qbit_in;
   logic [63:0]  rem_in;
   logic [126:0] num_in;
   assign rtrial_in = {rem_ff, num_ff[126]};
   assign qbit_in   = (rtrial_in >= {1'b0, len_ff});
   assign rem_in    = qbit_in ? 64'(rtrial_in - {1'b0, len_ff}) : rtrial_in[63:0];
   assign num_in    = {num_ff[125:0], qbit_in};

   // square root step
   logic [127:0] t_in;
   logic         take_in;
   logic [126:0] sn_in;
   logic [127:0] res_in;
   assign t_in    = res_ff + {1'b0, bit_ff};
   assign take_in = ({1'b0, sn_ff} >= t_in);
   assign sn_in   = take_in ? 127'({1'b0, sn_ff} - t_in) : sn_ff;
   assign res_in  = take_in ? ((res_ff >> 1) + {1'b0, bit_ff}) : (res_ff >> 1);

   // rounding, clamp and placement of one component
   logic [127:0]       rnd_in;
   logic [79:0]        pq_in;
   logic               negk_in;
   logic [31:0]        lim_in, mm_in;
   logic signed [33:0] comp_in, place_in;
   coord_type          pak_in;
   always_comb begin
      case (k_ff)
         2'd0:    begin negk_in = neg_ff[0]; pak_in = pa_ff[0]; end
         2'd1:    begin negk_in = neg_ff[1]; pak_in = pa_ff[1]; end
         2'd2:    begin negk_in = neg_ff[2]; pak_in = pa_ff[2]; end
         default: begin negk_in = 1'b0;      pak_in = '0;       end
      endcase
      rnd_in   = acc_ff + (128'd1 << 47);
      pq_in    = rnd_in[127:48];
      lim_in   = negk_in ? 32'h80000000 : 32'h7FFFFFFF;
      mm_in    = (pq_in > {48'd0, lim_in}) ? lim_in : pq_in[31:0];
      comp_in  = negk_in ? -$signed({2'b00, mm_in}) : $signed({2'b00, mm_in});
      place_in = $signed({{2{pak_in[31]}}, pak_in}) + comp_in;
   end

   // RAM port control
   always_comb begin
      we_in    = 1'b0;
      waddr_in = m_ff;
      wdata_in = inpos_ff;
      raddr_in = (state_ff == S_RDA) ? a_ff : m_ff;
      if (state_ff == S_RDM && cmd_ff == CMD_WRITE) we_in = 1'b1;
      if (state_ff == S_WB) begin
         we_in    = 1'b1;
         wdata_in = {new_ff[2], new_ff[1], new_ff[0]};
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_cmd;
                  mraw_ff  <= req_moved_index;
                  araw_ff  <= req_anchor_index;
                  rest_ff  <= req_rest_sq_length;
                  inpos_ff <= {req_in_z, req_in_y, req_in_x};
                  state_ff <= S_IDX1;
               end
            end
            S_IDX1: begin
               qm_ff    <= qm_prod_in[39:28];
               qa_ff    <= qa_prod_in[39:28];
               state_ff <= S_IDX2;
            end
            S_IDX2: begin
               m_ff <= mrem_in[AW-1:0];
               a_ff <= arem_in[AW-1:0];
               if (cmd_ff == CMD_WRITE || cmd_ff == CMD_LIMIT || cmd_ff == CMD_READ) begin
                  state_ff <= S_RDM;
               end else begin
                  // unused code: no store change, zero beat
                  rsp_strobe_ff <= 1'b1;
                  rsp_x_ff      <= '0;
                  rsp_y_ff      <= '0;
                  rsp_z_ff      <= '0;
                  rsp_corr_ff   <= 1'b0;
                  rsp_deg_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_RDM: begin
               if (cmd_ff == CMD_WRITE) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_x_ff      <= inpos_ff[31:0];
                  rsp_y_ff      <= inpos_ff[63:32];
                  rsp_z_ff      <= inpos_ff[95:64];
                  rsp_corr_ff   <= 1'b0;
                  rsp_deg_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               pm_ff[0] <= rdata_ff[31:0];
               pm_ff[1] <= rdata_ff[63:32];
               pm_ff[2] <= rdata_ff[95:64];
               if (cmd_ff == CMD_READ) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_x_ff      <= rdata_ff[31:0];
                  rsp_y_ff      <= rdata_ff[63:32];
                  rsp_z_ff      <= rdata_ff[95:64];
                  rsp_corr_ff   <= 1'b0;
                  rsp_deg_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               for (int k = 0; k < 3; k++) begin
                  pa_ff[k]  <= dq_in[k];
                  mag_ff[k] <= dmag_in[k];
                  neg_ff[k] <= d_in[k][31];
               end
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               // squares are registered in prod_ff and summed into len_ff from there
               prod_ff  <= sq_in;
               len_ff   <= (cnt_ff == 7'd0) ? 64'd0 : (len_ff + prod_ff);
               cnt_ff   <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd3) state_ff <= S_CHK;
            end
            S_CHK: begin
               if (len_ff == 64'd0) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_x_ff      <= pm_ff[0];
                  rsp_y_ff      <= pm_ff[1];
                  rsp_z_ff      <= pm_ff[2];
                  rsp_corr_ff   <= 1'b0;
                  rsp_deg_ff    <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  acc_ff   <= '0;
                  mc_ff    <= {65'd0, rest_ff};
                  mp_ff    <= {47'd0, upper_ff};
                  state_ff <= S_MULU;
               end
            end
            S_MULU, S_MULL: begin
               if (!mul_done_in) begin
                  acc_ff <= acc_add_in;
                  mc_ff  <= mc_ff << 1;
                  mp_ff  <= mp_ff >> 1;
               end else if (state_ff == S_MULU && lsh_in > acc_ff[79:0]) begin
                  tgt_ff   <= stretch_ff;
                  num_ff   <= {rest_ff, 64'd0};
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else if (state_ff == S_MULU) begin
                  acc_ff   <= '0;
                  mc_ff    <= {65'd0, rest_ff};
                  mp_ff    <= {47'd0, lower_ff};
                  state_ff <= S_MULL;
               end else if (lsh_in < acc_ff[79:0]) begin
                  tgt_ff   <= compress_ff;
                  num_ff   <= {rest_ff, 64'd0};
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  // inside the band: unchanged
                  rsp_strobe_ff <= 1'b1;
                  rsp_x_ff      <= pm_ff[0];
                  rsp_y_ff      <= pm_ff[1];
                  rsp_z_ff      <= pm_ff[2];
                  rsp_corr_ff   <= 1'b0;
                  rsp_deg_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_DIV: begin
               num_ff <= num_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd126) begin
                  sn_ff    <= num_in;
                  res_ff   <= '0;
                  bit_ff   <= 127'd1 << 126;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               sn_ff  <= sn_in;
               res_ff <= res_in;
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) begin
                  k_ff     <= 2'd0;
                  state_ff <= S_MT;
               end
            end
            S_MT: begin
               mp_ff    <= mt_in;
               mc_ff    <= {64'd0, res_ff[63:0]};
               acc_ff   <= '0;
               state_ff <= S_MULS;
            end
            S_MULS: begin
               if (!mul_done_in) begin
                  acc_ff <= acc_add_in;
                  mc_ff  <= mc_ff << 1;
                  mp_ff  <= mp_ff >> 1;
               end else begin
                  case (k_ff)
                     2'd0:    new_ff[0] <= sat34(place_in);
                     2'd1:    new_ff[1] <= sat34(place_in);
                     default: new_ff[2] <= sat34(place_in);
                  endcase
                  if (k_ff == 2'd2) begin
                     state_ff <= S_WB;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= S_MT;
                  end
               end
            end
            S_WB: begin
               rsp_strobe_ff <= 1'b1;
               rsp_x_ff      <= new_ff[0];
               rsp_y_ff      <= new_ff[1];
               rsp_z_ff      <= new_ff[2];
               rsp_corr_ff   <= 1'b1;
               rsp_deg_ff    <= 1'b0;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_z      = rsp_z_ff;
   assign rsp_corrected  = rsp_corr_ff;
   assign rsp_degenerate = rsp_deg_ff;
endmodule
`default_nettype wire

// File: design/ssl_checker.sv
// Port-level checker for the strain limiter, bound to the top level.
`default_nettype none
`include "segment_strain_limiter_macros.svh"
module ssl_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_corrected,
   input wire logic rsp_degenerate
);
   // every command passes through the index states before its beat, so beats never run back to back
   `SSL_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   // an accepted command holds the block busy
   `SSL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // a beat is launched as the block frees up
   `SSL_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy)
   // a skipped segment is never also corrected
   `SSL_ASSERT_NOW(a_flags_excl, rsp_strobe, !(rsp_corrected && rsp_degenerate))
endmodule

bind segment_strain_limiter ssl_checker u_ssl_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_corrected  (rsp_corrected),
   .rsp_degenerate (rsp_degenerate)
);
`default_nettype wire

// File: dv/tb.sv
// Testbench for the segment strain limiter: random and directed commands against a predictor.
`default_nettype none
module tb;
   import ssl_pkg::*;

   localparam int  NPART       = PARTICLES_DEFAULT;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  SETTLE      = 500;   // covers the longest limit latency and its write-back
   localparam logic [1:0] CMD_NOP = 2'd3;

   // One command beat.
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   mi;
      logic [IDX_W-1:0]   ai;
      logic [REST_W-1:0]  rest;
      coord_type          x, y, z;
   } cmd_beat_type;

   // One result beat.
   typedef struct {
      coord_type x, y, z;
      logic      corrected;
      logic      degenerate;
   } pos_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0]   req_cmd            = '0;
   logic [IDX_W-1:0]   req_moved_index    = '0;
   logic [IDX_W-1:0]   req_anchor_index   = '0;
   logic [REST_W-1:0]  req_rest_sq_length = '0;
   coord_type          req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic               rsp_strobe;
   coord_type          rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_corrected, rsp_degenerate;
   logic               csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]   csr_wdata = '0;

   segment_strain_limiter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_moved_index(req_moved_index),
      .req_anchor_index(req_anchor_index), .req_rest_sq_length(req_rest_sq_length),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .rsp_strobe(rsp_strobe), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_corrected(rsp_corrected),
      .rsp_degenerate(rsp_degenerate),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: its own copy of the position store and the ratio registers.
   coord_type   pos_x [NPART];
   coord_type   pos_y [NPART];
   coord_type   pos_z [NPART];
   logic [CFG_W-1:0] ratio_reg [4];

   cmd_beat_type pending_cmds[$];
   pos_beat_type expected_pos[$];
   int          idle_pct = 0;
   int          mismatches = 0;
   int          cycles = 0;

   // Generator bookkeeping: which entries hold a written position.
   bit          written [NPART];
   int          known_idx[$];

   // Saturate a wide signed value to Q16.16 range.
   function automatic coord_type clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)       return 32'sh7FFFFFFF;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   function automatic logic [63:0] root128(input logic [127:0] n);
      logic [127:0] res, bitv, t;
      res  = '0;
      bitv = 128'd1 << 126;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (n >= t) begin
            n   = n - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[63:0];
   endfunction

   // Anchor-relative component after rescaling, rounded half up, magnitude saturated.
   function automatic logic signed [65:0] rescale(input logic signed [65:0] d,
                                                  input logic [CFG_W-1:0] tgt,
                                                  input logic [63:0] f);
      logic [127:0] mag, lim, p;
      mag = (d < 0) ? 128'(-d) : 128'(d);
      lim = (d < 0) ? 128'd2147483648 : 128'd2147483647;
      p   = (mag * 128'(tgt) * 128'(f) + (128'd1 << 47)) >> 48;
      if (p > lim) p = lim;
      return (d < 0) ? -$signed({1'b0, p[64:0]}) : $signed({1'b0, p[64:0]});
   endfunction

   function automatic logic [63:0] seg_len_sq(input coord_type px, py, pz,
                                              input coord_type qx, qy, qz);
      logic signed [65:0] dx, dy, dz;
      dx = clamp32(66'(px) - 66'(qx));
      dy = clamp32(66'(py) - 66'(qy));
      dz = clamp32(66'(pz) - 66'(qz));
      return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
   endfunction

   // Applies one command to the predictor state and returns its result beat.
   function automatic pos_beat_type apply_cmd(input cmd_beat_type c);
      pos_beat_type r;
      logic signed [65:0] d [3];
      logic signed [65:0] q [3];
      logic [63:0]  len, f;
      logic [127:0] lsh;
      logic [CFG_W-1:0] tgt;
      int m, a;
      m = c.mi % NPART;
      a = c.ai % NPART;
      r = '{default: '0};
      if (c.cmd == CMD_WRITE) begin
         pos_x[m] = c.x; pos_y[m] = c.y; pos_z[m] = c.z;
      end
      if (c.cmd != CMD_NOP) begin
         r.x = pos_x[m]; r.y = pos_y[m]; r.z = pos_z[m];
      end
      if (c.cmd == CMD_LIMIT) begin
         q[0] = 66'(pos_x[a]); q[1] = 66'(pos_y[a]); q[2] = 66'(pos_z[a]);
         d[0] = clamp32(66'(r.x) - q[0]);
         d[1] = clamp32(66'(r.y) - q[1]);
         d[2] = clamp32(66'(r.z) - q[2]);
         len  = seg_len_sq(r.x, r.y, r.z, pos_x[a], pos_y[a], pos_z[a]);
         tgt  = '0;
         if (len == 0) begin
            r.degenerate = 1'b1;
         end else begin
            lsh = 128'(len) << 16;
            if (lsh > 128'(ratio_reg[REG_UPPER]) * 128'(c.rest)) begin
               r.corrected = 1'b1; tgt = ratio_reg[REG_STRETCH];
            end else if (lsh < 128'(ratio_reg[REG_LOWER]) * 128'(c.rest)) begin
               r.corrected = 1'b1; tgt = ratio_reg[REG_COMPRESS];
            end
            if (r.corrected) begin
               f   = root128((128'(c.rest) << 64) / 128'(len));
               r.x = clamp32(q[0] + rescale(d[0], tgt, f));
               r.y = clamp32(q[1] + rescale(d[1], tgt, f));
               r.z = clamp32(q[2] + rescale(d[2], tgt, f));
               pos_x[m] = r.x; pos_y[m] = r.y; pos_z[m] = r.z;
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic coord_type rand_coord();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         2:       return $signed($urandom_range(32'h0001_FFFF)) - 32'sh0001_0000;
         default: return $signed($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic logic [REST_W-1:0] rand_rest();
      return REST_W'({$urandom, $urandom} >> 1);
   endfunction

   function automatic logic [IDX_W-1:0] pick_known();
      return known_idx[$urandom_range(known_idx.size() - 1)];
   endfunction

   task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] mi,
                           input logic [IDX_W-1:0] ai, input logic [REST_W-1:0] rest,
                           input coord_type x, y, z);
      cmd_beat_type c;
      c = '{cmd: cmd, mi: mi, ai: ai, rest: rest, x: x, y: y, z: z};
      if (cmd == CMD_WRITE && !written[mi]) begin
         written[mi] = 1'b1;
         known_idx = {known_idx, int'(mi)};
      end
      pending_cmds = {pending_cmds, c};
   endtask

   // Well formed segment: write both ends, limit once or twice, sometimes read the result back.
   task automatic segment_seq();
      logic [IDX_W-1:0]  m, a;
      coord_type         mx, my, mz, ax, ay, az;
      logic [63:0]       len;
      logic [127:0]      scaled;
      logic [REST_W-1:0] rest;
      m  = $urandom_range(7) == 0 ? pick_known() : IDX_W'($urandom);
      a  = $urandom_range(15) == 0 ? m : IDX_W'($urandom);
      mx = rand_coord(); my = rand_coord(); mz = rand_coord();
      ax = $urandom_range(3) == 0 ? mx : rand_coord();
      ay = rand_coord(); az = rand_coord();
      push_cmd(CMD_WRITE, a, '0, rand_rest(), ax, ay, az);
      push_cmd(CMD_WRITE, m, '0, rand_rest(), mx, my, mz);
      len = (m == a) ? 64'd0 : seg_len_sq(mx, my, mz, ax, ay, az);
      // rest chosen around the current length so both bounds get crossed and missed
      scaled = (128'(len) * 128'($urandom_range(140, 30))) >> 7;
      rest   = (scaled == 0) ? 63'd1 : (scaled >> 63 != 0) ? {REST_W{1'b1}} : scaled[62:0];
      if ($urandom_range(9) == 0) rest = rand_rest();
      push_cmd(CMD_LIMIT, m, a, rest, rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(2) == 0)
         push_cmd(CMD_LIMIT, m, a, rest, rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(1) == 0)
         push_cmd(CMD_READ, m, IDX_W'($urandom), rand_rest(), rand_coord(), rand_coord(),
                  rand_coord());
   endtask

   // Noise: any command, unused code included; limits and reads use known entries.
   task automatic noise_cmd();
      logic [CMD_W-1:0] cmd;
      cmd = CMD_W'($urandom);
      if (cmd == CMD_WRITE)
         push_cmd(cmd, IDX_W'($urandom), IDX_W'($urandom), rand_rest(),
                  rand_coord(), rand_coord(), rand_coord());
      else if (cmd == CMD_NOP)
         push_cmd(cmd, IDX_W'($urandom), IDX_W'($urandom), rand_rest(),
                  rand_coord(), rand_coord(), rand_coord());
      else
         push_cmd(cmd, pick_known(), pick_known(), rand_rest(),
                  rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic directed_cmds();
      // extremes of position at the ends of the index range
      push_cmd(CMD_WRITE, 12'd0,    12'hABC, '0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
      push_cmd(CMD_WRITE, 12'hFFF,  12'h543, {REST_W{1'b1}},
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      push_cmd(CMD_READ,  12'hFFF,  12'd0, '0, '0, '0, '0);
      // saturating differences, both bounds with extreme rest lengths
      push_cmd(CMD_LIMIT, 12'd0,    12'hFFF, 63'd1, '0, '0, '0);
      push_cmd(CMD_LIMIT, 12'hFFF,  12'd0, {REST_W{1'b1}}, '0, '0, '0);
      push_cmd(CMD_READ,  12'd0,    12'd0, '0, '0, '0, '0);
      // zero rest length: placed onto the anchor
      push_cmd(CMD_WRITE, 12'd5,    12'd0, '0, 32'sh0001_0000, 32'sh0002_0000, -32'sh3_0000);
      push_cmd(CMD_LIMIT, 12'd5,    12'hFFF, '0, '0, '0, '0);
      // zero-length segment, distinct entries and moved equal to anchor
      push_cmd(CMD_WRITE, 12'd7,    12'd0, '0, 32'sh0001_0000, 32'sh0002_0000, -32'sh3_0000);
      push_cmd(CMD_WRITE, 12'd8,    12'd0, '0, 32'sh0001_0000, 32'sh0002_0000, -32'sh3_0000);
      push_cmd(CMD_LIMIT, 12'd7,    12'd8, 63'd12345, '0, '0, '0);
      push_cmd(CMD_LIMIT, 12'd8,    12'd8, 63'd12345, '0, '0, '0);
      // unit segment inside bounds, then above and below
      push_cmd(CMD_WRITE, 12'd9,    12'd0, '0, 32'sh0002_0000, 32'sh0002_0000, -32'sh3_0000);
      push_cmd(CMD_LIMIT, 12'd9,    12'd8, 63'h1_0000_0000, '0, '0, '0);
      push_cmd(CMD_LIMIT, 12'd9,    12'd8, 63'h0_4000_0000, '0, '0, '0);
      push_cmd(CMD_LIMIT, 12'd9,    12'd8, 63'h4_0000_0000, '0, '0, '0);
      push_cmd(CMD_READ,  12'd9,    12'd0, '0, '0, '0, '0);
      // unused code answers zeros
      push_cmd(CMD_NOP,   12'hFFF,  12'hFFF, {REST_W{1'b1}}, 32'sh7FFFFFFF, -32'sd1, 32'sd1);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      ratio_reg[idx] = v;
   endtask

   task automatic configure(input int sel);
      logic [CFG_W-1:0] v [4];
      for (int i = 0; i < 4; i++)
         case (sel)
            0:       v[i] = (i == 0) ? UPPER_RST : (i == 1) ? LOWER_RST :
                            (i == 2) ? STRETCH_RST : COMPRESS_RST;
            1:       v[i] = {CFG_W{1'b1}};
            2:       v[i] = '0;
            default: v[i] = CFG_W'($urandom);
         endcase
      csr_write(REG_UPPER, v[0]);
      csr_write(REG_LOWER, v[1]);
      csr_write(REG_STRETCH, v[2]);
      csr_write(REG_COMPRESS, v[3]);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until the block has drained, then its write-back latency.
   task automatic drain();
      while (pending_cmds.size() != 0 || start || expected_pos.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequencing
   initial begin : sequencer
      int phase_idle [6];
      int phase_cfg  [6];
      phase_idle = '{0, 84, 0, 29, 84, 0};
      phase_cfg  = '{0, 0, 1, 2, 3, 3};
      for (int i = 0; i < NPART; i++) begin
         pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0;
      end
      ratio_reg[REG_UPPER]    = UPPER_RST;
      ratio_reg[REG_LOWER]    = LOWER_RST;
      ratio_reg[REG_STRETCH]  = STRETCH_RST;
      ratio_reg[REG_COMPRESS] = COMPRESS_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_cmds();   // runs on reset defaults, before any register write
      drain();
      for (int p = 0; p < 6; p++) begin
         configure(phase_cfg[p]);
         idle_pct = phase_idle[p];
         // generation stays ahead of the driver; each phase ends in a full drain
         while (pending_cmds.size() < 100) begin
            if ($urandom_range(4) == 0) noise_cmd();
            else                        segment_seq();
         end
         drain();
      end
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   // A presented beat stays up until taken; a new one is chosen only on acceptance or idle.
   always @(posedge clock) begin : driver
      cmd_beat_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_pos = {expected_pos, apply_cmd(nxt)};
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_cmds.pop_front();
               start              <= 1'b1;
               req_cmd            <= nxt.cmd;
               req_moved_index    <= nxt.mi;
               req_anchor_index   <= nxt.ai;
               req_rest_sq_length <= nxt.rest;
               req_in_x           <= nxt.x;
               req_in_y           <= nxt.y;
               req_in_z           <= nxt.z;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : monitor
      pos_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: result beat with nothing outstanding");
         end else begin
            want = expected_pos.pop_front();
            if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z ||
                rsp_corrected !== want.corrected || rsp_degenerate !== want.degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: mismatch exp %h %h %h c%b d%b got %h %h %h c%b d%b",
                           want.x, want.y, want.z, want.corrected, want.degenerate,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_corrected, rsp_degenerate);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end
endmodule
`default_nettype wire
